### rtl/oae_pkg.sv
// shared types and constants for the ordered array engine
// no dependencies; imported by every module of the block
`default_nettype none

package oae_pkg;

  localparam int DEPTH_DEF  = 32;
  localparam int DATA_W     = 32;
  localparam int CMD_W      = 3;
  localparam int POS_W      = 6;
  localparam int ST_W       = 2;
  localparam int ADDR_MAX_W = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND  = 3'd0,
    CMD_INSERT  = 3'd1,
    CMD_DELETE  = 3'd2,
    CMD_READ    = 3'd3,
    CMD_REVERSE = 3'd4,
    CMD_SORT    = 3'd5,
    CMD_ROTATE  = 3'd6
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // how the pair pointers move after each compare-exchange
  typedef enum logic [1:0] {
    WALK_DOWN,
    WALK_UP,
    WALK_SORT,
    WALK_REV
  } walk_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDA,
    S_RDB,
    S_CMP,
    S_WRB,
    S_RO_RD,
    S_RO_PUT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                  we;
    logic                  re;
    logic [ADDR_MAX_W-1:0] addr;
    logic [DATA_W-1:0]     wdata;
  } mem_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              has;
    status_t           status;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

### rtl/oae_mem.sv
// element store: single-port synchronous ram with registered read data
// depends on oae_pkg for the request struct
`default_nettype none

module oae_mem #(
  parameter int DEPTH = oae_pkg::DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire oae_pkg::mem_req_t        req,
  output logic [oae_pkg::DATA_W-1:0]    rdata
);
  import oae_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr[AW-1:0]] <= req.wdata;
    end
    // read data holds until the next read
    if (req.re) begin
      rdata_r <= mem[req.addr[AW-1:0]];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/oae_ctrl.sv
// command sequencer: decodes an item and walks the store by compare-exchange
// of adjacent or mirrored pairs; depends on oae_pkg
`default_nettype none

module oae_ctrl #(
  parameter int DEPTH = oae_pkg::DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [oae_pkg::CMD_W-1:0]     in_command,
  input  wire logic [oae_pkg::POS_W-1:0]     in_position,
  input  wire logic signed [oae_pkg::DATA_W-1:0] in_item_value,
  input  wire logic                          slot_free,
  output logic                               res_load,
  output oae_pkg::res_t                      res,
  output logic [CNT_W-1:0]                   count,
  output oae_pkg::mem_req_t                  mem_req,
  input  wire logic [oae_pkg::DATA_W-1:0]    mem_rdata
);
  import oae_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  state_t            state_r, state_nxt;
  walk_t             mode_r, mode_nxt;
  logic [AW-1:0]     a_r, a_nxt;
  logic [AW-1:0]     b_r, b_nxt;
  logic [AW-1:0]     lim_r, lim_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  status_t           status_r, status_nxt;
  logic [DATA_W-1:0] hold_r, hold_nxt;

  logic [CMP_W-1:0]  pos_ext, cnt_ext;
  logic              full;
  logic              many;
  logic              walk_done;
  logic              do_swap;
  logic              ro_last;
  logic [AW-1:0]     a_step, b_step, lim_step;

  assign pos_ext = CMP_W'(in_position);
  assign cnt_ext = CMP_W'(count_r);
  assign full    = (count_r == CNT_W'(DEPTH));
  assign many    = (count_r >= CNT_W'(2));
  assign ro_last = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
  assign do_swap = (mode_r != WALK_SORT) || ($signed(hold_r) > $signed(mem_rdata));

  // pointer advance after one pair is finished
  always_comb begin
    walk_done = 1'b0;
    a_step    = a_r;
    b_step    = b_r;
    lim_step  = lim_r;
    unique case (mode_r)
      WALK_DOWN: begin
        walk_done = (a_r == lim_r);
        a_step    = a_r - AW'(1);
        b_step    = b_r - AW'(1);
      end
      WALK_UP: begin
        walk_done = (b_r == lim_r);
        a_step    = a_r + AW'(1);
        b_step    = b_r + AW'(1);
      end
      WALK_SORT: begin
        if (b_r == lim_r) begin
          // end of a pass: the top entry is settled
          walk_done = (lim_r == AW'(1));
          lim_step  = lim_r - AW'(1);
          a_step    = '0;
          b_step    = AW'(1);
        end else begin
          a_step = a_r + AW'(1);
          b_step = b_r + AW'(1);
        end
      end
      WALK_REV: begin
        walk_done = ((AW+1)'(b_r) <= ((AW+1)'(a_r) + (AW+1)'(2)));
        a_step    = a_r + AW'(1);
        b_step    = b_r - AW'(1);
      end
      default: walk_done = 1'b1;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    lim_nxt    = lim_r;
    idx_nxt    = idx_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    hold_nxt   = hold_r;
    mem_req    = '0;
    res_load   = 1'b0;
    res        = '{value: '0, has: 1'b0, status: status_r, last: 1'b1};

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          status_nxt = ST_OK;
          state_nxt  = S_DONE;
          unique case (cmd_t'(in_command)) inside
            CMD_APPEND, CMD_INSERT: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else if ((cmd_t'(in_command) == CMD_INSERT) && (pos_ext > cnt_ext)) begin
                status_nxt = ST_RANGE;
              end else begin
                // place at the end, then bubble down to the index
                mem_req.we    = 1'b1;
                mem_req.addr  = ADDR_MAX_W'(count_r);
                mem_req.wdata = in_item_value;
                count_nxt     = count_r + CNT_W'(1);
                if ((cmd_t'(in_command) == CMD_INSERT) && (pos_ext < cnt_ext)) begin
                  mode_nxt  = WALK_DOWN;
                  a_nxt     = AW'(count_r - CNT_W'(1));
                  b_nxt     = AW'(count_r);
                  lim_nxt   = AW'(in_position);
                  state_nxt = S_RDA;
                end
              end
            end
            CMD_DELETE: begin
              if (pos_ext >= cnt_ext) begin
                status_nxt = ST_RANGE;
              end else begin
                // carry the doomed entry past the end
                count_nxt = count_r - CNT_W'(1);
                if (pos_ext < (cnt_ext - CMP_W'(1))) begin
                  mode_nxt  = WALK_UP;
                  a_nxt     = AW'(in_position);
                  b_nxt     = AW'(in_position) + AW'(1);
                  lim_nxt   = AW'(count_r - CNT_W'(1));
                  state_nxt = S_RDA;
                end
              end
            end
            CMD_READ: begin
              if (count_r != '0) begin
                idx_nxt   = '0;
                state_nxt = S_RO_RD;
              end
            end
            CMD_REVERSE: begin
              if (many) begin
                mode_nxt  = WALK_REV;
                a_nxt     = '0;
                b_nxt     = AW'(count_r - CNT_W'(1));
                state_nxt = S_RDA;
              end
            end
            CMD_SORT: begin
              if (many) begin
                mode_nxt  = WALK_SORT;
                a_nxt     = '0;
                b_nxt     = AW'(1);
                lim_nxt   = AW'(count_r - CNT_W'(1));
                state_nxt = S_RDA;
              end
            end
            CMD_ROTATE: begin
              if (many) begin
                mode_nxt  = WALK_DOWN;
                a_nxt     = AW'(count_r - CNT_W'(2));
                b_nxt     = AW'(count_r - CNT_W'(1));
                lim_nxt   = '0;
                state_nxt = S_RDA;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_RDA: begin
        mem_req.re   = 1'b1;
        mem_req.addr = ADDR_MAX_W'(a_r);
        state_nxt    = S_RDB;
      end
      S_RDB: begin
        mem_req.re   = 1'b1;
        mem_req.addr = ADDR_MAX_W'(b_r);
        hold_nxt     = mem_rdata;
        state_nxt    = S_CMP;
      end
      S_CMP: begin
        if (do_swap) begin
          mem_req.we    = 1'b1;
          mem_req.addr  = ADDR_MAX_W'(a_r);
          mem_req.wdata = mem_rdata;
          state_nxt     = S_WRB;
        end else begin
          a_nxt     = a_step;
          b_nxt     = b_step;
          lim_nxt   = lim_step;
          state_nxt = walk_done ? S_DONE : S_RDA;
        end
      end
      S_WRB: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = ADDR_MAX_W'(b_r);
        mem_req.wdata = hold_r;
        a_nxt         = a_step;
        b_nxt         = b_step;
        lim_nxt       = lim_step;
        state_nxt     = walk_done ? S_DONE : S_RDA;
      end
      S_RO_RD: begin
        mem_req.re   = 1'b1;
        mem_req.addr = ADDR_MAX_W'(idx_r);
        state_nxt    = S_RO_PUT;
      end
      S_RO_PUT: begin
        res = '{value: mem_rdata, has: 1'b1, status: ST_OK, last: ro_last};
        if (slot_free) begin
          res_load = 1'b1;
          if (ro_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = S_RO_RD;
          end
        end
      end
      S_DONE: begin
        if (slot_free) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    lim_r    <= lim_nxt;
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    hold_r   <= hold_nxt;
  end

  assign in_ready = (state_r == S_IDLE);
  assign count    = count_r;

endmodule

`default_nettype wire

### rtl/ordered_array_engine.sv
// ordered array engine: top level with the result register
// depends on oae_pkg, oae_mem and oae_ctrl
//
// one command item in on in_*, one or more result items out on out_*, both
// valid/ready. the elements sit in a single-port ram of DEPTH entries, so
// every reordering is done as a series of pair exchanges through that one port.
// work per command item, n = element count:
//   append, refused commands, short arrays, unused codes: no pair walk
//   insert / delete: one pair exchange per entry moved
//   rotate: n-1 pair exchanges; reverse: n/2 pair exchanges
//   sort: n*(n-1)/2 compare-exchanges, a pair already in order is only read
//   read out: one ram read and one result item per element
// the ram port sets the pace: a swapped pair needs two reads and two writes.
// a result item is valid the cycle after the sequencer produces it.
// in_ready is high only between commands; it does not wait for the result
// register to drain, which holds one item while out_ready is low. a stall
// on the output freezes the sequencer at its next result.
// reset empties the array (count zero) and drops any pending result; ram
// contents are not cleared, entries above the count are never read.
`default_nettype none

module ordered_array_engine #(
  parameter int DEPTH = oae_pkg::DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [oae_pkg::CMD_W-1:0]         in_command,
  input  wire logic [oae_pkg::POS_W-1:0]         in_position,
  input  wire logic signed [oae_pkg::DATA_W-1:0] in_item_value,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [oae_pkg::DATA_W-1:0]      out_value,
  output logic                                   out_has_value,
  output logic [CNT_W-1:0]                       out_element_count,
  output logic [oae_pkg::ST_W-1:0]               out_status,
  output logic                                   out_last
);
  import oae_pkg::*;

  mem_req_t          mem_req;
  logic [DATA_W-1:0] mem_rdata;
  logic              slot_free;
  logic              res_load;
  res_t              res;
  logic [CNT_W-1:0]  count;

  logic              out_valid_r;
  res_t              res_r;
  logic [CNT_W-1:0]  count_r;

  oae_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  oae_ctrl #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_position   (in_position),
    .in_item_value (in_item_value),
    .slot_free     (slot_free),
    .res_load      (res_load),
    .res           (res),
    .count         (count),
    .mem_req       (mem_req),
    .mem_rdata     (mem_rdata)
  );

  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r   <= res;
      count_r <= count;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_value         = res_r.value;
  assign out_has_value     = res_r.has;
  assign out_element_count = count_r;
  assign out_status        = res_r.status;
  assign out_last          = res_r.last;

endmodule

`default_nettype wire

### rtl/oae_checker.sv
// port-level checks for the ordered array engine, bound to the top level
// depends on oae_pkg and ordered_array_engine
`default_nettype none

module oae_checker #(
  parameter int DEPTH = oae_pkg::DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic signed [oae_pkg::DATA_W-1:0] out_value,
  input wire logic                              out_has_value,
  input wire logic [CNT_W-1:0]                  out_element_count,
  input wire logic [oae_pkg::ST_W-1:0]          out_status,
  input wire logic                              out_last
);
  import oae_pkg::*;

  // a held result item keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value)
      && $stable(out_element_count) && $stable(out_last))
    else $error("result item changed while stalled");

  // no element carried means a zero value
  a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_value |-> out_value == '0)
    else $error("value without element flag");

  // refusals are single, final items
  a_refusal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_last && !out_has_value)
    else $error("refused command with a stream");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_element_count <= CNT_W'(DEPTH))
    else $error("element count beyond depth");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind ordered_array_engine oae_checker #(
  .DEPTH (DEPTH),
  .CNT_W (CNT_W)
) u_oae_checker (.*);

`default_nettype wire

### tb/sv/ordered_array_engine_tb.sv
// self-checking testbench for ordered_array_engine: a directed item set, then
// random command items in four phases of sender idles and receiver stalls, each result checked field by field
// depends on oae_pkg and the ordered_array_engine rtl
`timescale 1ns / 100ps

module ordered_array_engine_tb;
  import oae_pkg::*;

  localparam int ARR_DEPTH = DEPTH_DEF;
  localparam int CNT_W     = $clog2(ARR_DEPTH + 1);
  localparam logic [CMD_W-1:0] CMD_SPARE = 3'd7;  // no operation behind this code
  localparam int TAIL_CYCLES = 50;

  typedef struct {
    logic [CMD_W-1:0]         command;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } cmd_item_t;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     has;
    logic [CNT_W-1:0]         count;
    logic [ST_W-1:0]          status;
    logic                     last;
  } array_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [CMD_W-1:0] in_command = '0;
  logic [POS_W-1:0] in_position = '0;
  logic signed [DATA_W-1:0] in_item_value = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  logic signed [DATA_W-1:0] out_value;
  logic out_has_value;
  logic [CNT_W-1:0] out_element_count;
  logic [ST_W-1:0] out_status;
  logic out_last;

  ordered_array_engine dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_position      (in_position),
    .in_item_value    (in_item_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_value        (out_value),
    .out_has_value    (out_has_value),
    .out_element_count(out_element_count),
    .out_status       (out_status),
    .out_last         (out_last)
  );

  always #5 clk = ~clk;

  cmd_item_t     cmd_backlog[$];
  array_result_t due_results[$];
  cmd_item_t     on_wire;
  cmd_item_t     next_cmd;
  array_result_t want;

  // mirror of the engine's array
  logic signed [DATA_W-1:0] mirror_elems[ARR_DEPTH];
  int mirror_count = 0;
  // element count as the generator sees it, ahead of the mirror
  int gen_count = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int items_taken = 0;
  int results_checked = 0;
  int refused_full = 0;
  int refused_range = 0;
  int long_sorts = 0;

  function automatic void push_result(logic signed [DATA_W-1:0] v, logic h,
                                      logic [ST_W-1:0] st, logic l);
    array_result_t r;
    r.value  = v;
    r.has    = h;
    r.count  = mirror_count[CNT_W-1:0];
    r.status = st;
    r.last   = l;
    due_results.push_back(r);
  endfunction

  task automatic predict_array_cmd(input cmd_item_t c);
    logic signed [DATA_W-1:0] t;
    logic [ST_W-1:0] st;
    int i, j, at;
    st = ST_OK;
    case (c.command)
      CMD_APPEND, CMD_INSERT: begin
        // append is an insert at the current end
        at = (c.command == CMD_APPEND) ? mirror_count : int'(c.position);
        if (mirror_count >= ARR_DEPTH) begin
          st = ST_FULL;
          refused_full++;
        end else if (at > mirror_count) begin
          st = ST_RANGE;
          refused_range++;
        end else begin
          for (i = mirror_count; i > at; i--) mirror_elems[i] = mirror_elems[i-1];
          mirror_elems[at] = c.value;
          mirror_count++;
        end
      end
      CMD_DELETE: begin
        at = int'(c.position);
        if (at >= mirror_count) begin
          st = ST_RANGE;
          refused_range++;
        end else begin
          for (i = at; i + 1 < mirror_count; i++) mirror_elems[i] = mirror_elems[i+1];
          mirror_count--;
        end
      end
      CMD_READ: begin
        if (mirror_count == 0) begin
          push_result('0, 1'b0, ST_OK, 1'b1);
        end else begin
          for (i = 0; i < mirror_count; i++)
            push_result(mirror_elems[i], 1'b1, ST_OK, i == mirror_count - 1);
        end
      end
      CMD_REVERSE: begin
        for (i = 0; i < mirror_count / 2; i++) begin
          t = mirror_elems[i];
          mirror_elems[i] = mirror_elems[mirror_count-1-i];
          mirror_elems[mirror_count-1-i] = t;
        end
      end
      CMD_SORT: begin
        if (mirror_count > 16) long_sorts++;
        for (i = 0; i < mirror_count; i++) begin
          for (j = 0; j + 1 + i < mirror_count; j++) begin
            if (mirror_elems[j] > mirror_elems[j+1]) begin
              t = mirror_elems[j];
              mirror_elems[j] = mirror_elems[j+1];
              mirror_elems[j+1] = t;
            end
          end
        end
      end
      CMD_ROTATE: begin
        if (mirror_count >= 2) begin
          t = mirror_elems[mirror_count-1];
          for (i = mirror_count - 1; i > 0; i--) mirror_elems[i] = mirror_elems[i-1];
          mirror_elems[0] = t;
        end
      end
      default: ;
    endcase
    if (c.command != CMD_READ) push_result('0, 1'b0, st, 1'b1);
  endtask

  task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input int pos,
                           input logic signed [DATA_W-1:0] v);
    cmd_item_t c;
    c.command  = cmd;
    c.position = pos[POS_W-1:0];
    c.value    = v;
    case (cmd)
      CMD_APPEND: if (gen_count < ARR_DEPTH) gen_count++;
      CMD_INSERT: if (gen_count < ARR_DEPTH && pos <= gen_count) gen_count++;
      CMD_DELETE: if (pos < gen_count) gen_count--;
      default: ;
    endcase
    cmd_backlog.push_back(c);
  endtask

  // mostly a valid index, sometimes the first bad one, sometimes anything
  function automatic int pick_position(int span);
    int r;
    r = $urandom_range(99);
    if (span > 0 && r < 70) return $urandom_range(span - 1);
    if (r < 85) return span;
    return $urandom_range(2**POS_W - 1);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return -1;
      4: return $signed($urandom_range(15)) - 8;  // small values give duplicates
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_random_item(input bit grow);
    int r;
    r = $urandom_range(99);
    if (grow) begin
      if (r < 35)      queue_cmd(CMD_APPEND, $urandom_range(63), pick_value());
      else if (r < 65) queue_cmd(CMD_INSERT, pick_position(gen_count + 1), pick_value());
      else if (r < 73) queue_cmd(CMD_DELETE, pick_position(gen_count), pick_value());
      else if (r < 81) queue_cmd(CMD_READ, $urandom_range(63), pick_value());
      else if (r < 87) queue_cmd(CMD_REVERSE, $urandom_range(63), pick_value());
      else if (r < 91) queue_cmd(CMD_SORT, $urandom_range(63), pick_value());
      else if (r < 98) queue_cmd(CMD_ROTATE, $urandom_range(63), pick_value());
      else             queue_cmd(CMD_SPARE, $urandom_range(63), pick_value());
    end else begin
      if (r < 8)       queue_cmd(CMD_APPEND, $urandom_range(63), pick_value());
      else if (r < 16) queue_cmd(CMD_INSERT, pick_position(gen_count + 1), pick_value());
      else if (r < 60) queue_cmd(CMD_DELETE, pick_position(gen_count), pick_value());
      else if (r < 72) queue_cmd(CMD_READ, $urandom_range(63), pick_value());
      else if (r < 80) queue_cmd(CMD_REVERSE, $urandom_range(63), pick_value());
      else if (r < 86) queue_cmd(CMD_SORT, $urandom_range(63), pick_value());
      else if (r < 96) queue_cmd(CMD_ROTATE, $urandom_range(63), pick_value());
      else             queue_cmd(CMD_SPARE, $urandom_range(63), pick_value());
    end
  endtask

  // hold back until every queued item has gone in and every result has come out
  task automatic drain();
    while (cmd_backlog.size() != 0 || in_valid || due_results.size() != 0)
      @(posedge clk);
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_array_cmd(on_wire);
        items_taken++;
      end
      if (!in_valid || in_ready) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_cmd = cmd_backlog.pop_front();
          on_wire = next_cmd;
          in_valid <= 1'b1;
          in_command <= next_cmd.command;
          in_position <= next_cmd.position;
          in_item_value <= next_cmd.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $error("result item with nothing outstanding: value %0d count %0d status %0d",
                 out_value, out_element_count, out_status);
          errors++;
        end else begin
          want = due_results.pop_front();
          results_checked++;
          if (out_value !== want.value) begin
            $error("out_value: expected %0d, got %0d", want.value, out_value);
            errors++;
          end
          if (out_has_value !== want.has) begin
            $error("out_has_value: expected %0d, got %0d", want.has, out_has_value);
            errors++;
          end
          if (out_element_count !== want.count) begin
            $error("out_element_count: expected %0d, got %0d", want.count,
                   out_element_count);
            errors++;
          end
          if (out_status !== want.status) begin
            $error("out_status: expected %0d, got %0d", want.status, out_status);
            errors++;
          end
          if (out_last !== want.last) begin
            $error("out_last: expected %0d, got %0d", want.last, out_last);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    int phase, n;
    bit grow;
    grow = 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // empty array corner cases
    queue_cmd(CMD_READ, 0, '0);
    queue_cmd(CMD_DELETE, 0, '0);
    queue_cmd(CMD_REVERSE, 0, '0);
    queue_cmd(CMD_SORT, 0, '0);
    queue_cmd(CMD_ROTATE, 0, '0);
    queue_cmd(CMD_INSERT, 1, 32'sd9);
    // insert at the end of an empty array, then single-element rotate
    queue_cmd(CMD_INSERT, 0, 32'sd5);
    queue_cmd(CMD_ROTATE, 0, '0);
    queue_cmd(CMD_APPEND, 63, 32'sh7fff_ffff);
    queue_cmd(CMD_APPEND, 0, 32'sh8000_0000);
    queue_cmd(CMD_APPEND, 0, -1);
    queue_cmd(CMD_APPEND, 0, '0);
    queue_cmd(CMD_INSERT, 2, 32'sd77);
    queue_cmd(CMD_INSERT, 6, -32'sd3);
    queue_cmd(CMD_SPARE, 63, 32'sh5a5a_a5a5);
    queue_cmd(CMD_ROTATE, 0, '0);
    queue_cmd(CMD_REVERSE, 0, '0);
    queue_cmd(CMD_SORT, 0, '0);
    queue_cmd(CMD_READ, 0, '0);
    queue_cmd(CMD_DELETE, 63, '0);
    queue_cmd(CMD_DELETE, 0, '0);
    queue_cmd(CMD_DELETE, 5, '0);
    queue_cmd(CMD_READ, 0, '0);
    drain();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      for (n = 0; n < 112; n++) begin
        // swing the array between empty and full
        if (grow && gen_count >= ARR_DEPTH && $urandom_range(7) == 0) grow = 1'b0;
        else if (!grow && gen_count == 0 && $urandom_range(2) == 0) grow = 1'b1;
        queue_random_item(grow);
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (due_results.size() != 0) begin
      $error("%0d result items never arrived", due_results.size());
      errors++;
    end
    $display("covered %0d command items and %0d result items, %0d sorts of long arrays",
             items_taken, results_checked, long_sorts);
    $display("refusals seen: %0d array full, %0d index out of range",
             refused_full, refused_range);
    if (errors == 0) begin
      $display("PASS ordered_array_engine");
    end else begin
      $display("FAIL ordered_array_engine");
    end
    $finish;
  end

  // hang guard, far beyond a run where every item is a full-length sort
  initial begin
    #60_000_000;
    $display("FAIL ordered_array_engine");
    $finish;
  end

endmodule
